### src/tpsl_pkg.sv
// ----------------------------------------------------------------------------
// tpsl_pkg
// shared types, sizes and helpers for the trie prefix-share length block
// ----------------------------------------------------------------------------
package tpsl_pkg;

	localparam int NODE_COUNT   = 4096;
	localparam int ALPHABET     = 26;
	localparam int MAX_WORD_LEN = 1023;

	localparam int LETTER_W = 5;
	localparam int LEN_W    = 10;
	localparam int CNT_W    = 2;
	localparam int NODE_W   = $clog2(NODE_COUNT);
	localparam int FREE_W   = $clog2(NODE_COUNT + 1);
	localparam int SLOTS    = NODE_COUNT * ALPHABET;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int LEN_CAP  = (MAX_WORD_LEN < 1023) ? MAX_WORD_LEN : 1023;

	localparam logic [CNT_W-1:0] PASS_MAX = 2'd3;
	localparam logic [CNT_W-1:0] PASS_ONE = 2'd1;

	localparam logic [0:0] CMD_INSERT = 1'b0;
	localparam logic [0:0] CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [LETTER_W-1:0] letter;
		logic                word_end;
	} in_word_t;

	typedef struct packed {
		logic [LEN_W-1:0] prefix_len;
		logic             pool_full;
	} out_word_t;

	// child slot entry: pointer to the child node plus that child's pass count
	// (every node but the root has exactly one parent slot)
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [NODE_W-1:0] ptr;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic load;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic hold_last;
		logic out_busy;
	} ctl_status_t;

	function automatic logic sym_bad(input logic [LETTER_W-1:0] letter);
		logic [6:0] alpha;
		alpha = 7'(ALPHABET);
		return {2'b00, letter} >= alpha;
	endfunction

endpackage

### src/trie_prefix_share_length.sv
// ----------------------------------------------------------------------------
// trie_prefix_share_length
// letter-serial trie: inserts build a node-pool trie with pass counts,
// queries report the longest prefix shared with another inserted word
// ----------------------------------------------------------------------------
//
//  channel   direction  word type   fields
//  in        input      in_word_t   cmd, letter, word_end
//  out       output     out_word_t  prefix_len, pool_full (word_end only)
//
//  each letter: accept issues the child-slot read, then the execute state
//  uses the registered read data and writes the slot back
//  a last letter waits in the execute state while the result register is full
//  after reset a clearing pass zeroes all NODE_COUNT * ALPHABET slots (106496)
//  of the child table, one slot a cycle, with in_ready low
//  the result register lets the next letter in while a result waits
//
module trie_prefix_share_length (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tpsl_pkg::in_word_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tpsl_pkg::out_word_t out_item
);
	import tpsl_pkg::*;

	// controller to datapath commands and status back
	ctl_cmd_t    cmd;
	ctl_status_t status;

	// state machine: clear sweep, idle (ready), execute
	tpsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// child table memory (pointer plus child pass count per slot), walk state
	// and the output register
	tpsl_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

### src/tpsl_ctrl.sv
// ----------------------------------------------------------------------------
// tpsl_ctrl
// sequencer: memory clear after reset, then accept / execute per letter
// ----------------------------------------------------------------------------
module tpsl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tpsl_pkg::ctl_status_t status,
	output tpsl_pkg::ctl_cmd_t    cmd
);
	import tpsl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   stall;

	assign stall = status.hold_last && status.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!stall) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.load       = 1'b0;
		cmd.finish     = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: cmd.finish = !stall;
			default: ;
		endcase
	end

endmodule

### src/tpsl_datapath.sv
// ----------------------------------------------------------------------------
// tpsl_datapath
// child-slot memory, walk registers, node allocator and result register
// ----------------------------------------------------------------------------
module tpsl_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tpsl_pkg::in_word_t    in_item,
	input  tpsl_pkg::ctl_cmd_t    cmd,
	output tpsl_pkg::ctl_status_t status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tpsl_pkg::out_word_t   out_item
);
	import tpsl_pkg::*;

	localparam logic [SLOT_W-1:0] ALPHA_S   = SLOT_W'(ALPHABET);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
	localparam logic [FREE_W-1:0] FREE_END  = FREE_W'(NODE_COUNT);
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(LEN_CAP);

	entry_t mem [SLOTS];

	logic [SLOT_W-1:0] clr_cnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_d;
	in_word_t          item_q;
	entry_t            rdata_q;
	logic [NODE_W-1:0] cursor_q;
	logic [FREE_W-1:0] free_q;
	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  matched_q;
	logic              halted_q;
	logic              ovf_q;
	logic              out_valid_q;
	out_word_t         out_item_q;

	logic              mem_re;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	entry_t            mem_wdata;

	logic              exec_we;
	entry_t            exec_wdata;
	logic [NODE_W-1:0] cursor_d;
	logic [FREE_W-1:0] free_d;
	logic [LEN_W-1:0]  pos_d;
	logic [LEN_W-1:0]  matched_d;
	logic              halted_d;
	logic              ovf_d;
	logic              active;

	// slot of (cursor, letter) in the flat child table
	assign slot_d = SLOT_W'(SLOT_W'(cursor_q) * ALPHA_S) + SLOT_W'(in_item.letter);
	assign mem_re = cmd.load && !halted_q && !sym_bad(in_item.letter);

	assign mem_we    = cmd.clear_step || (cmd.finish && exec_we);
	assign mem_waddr = cmd.clear_step ? clr_cnt_q : slot_q;
	assign mem_wdata = cmd.clear_step ? entry_t'('0) : exec_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[slot_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step && !status.clear_done) begin
			clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			slot_q <= slot_d;
		end
	end

	// one letter of the walk
	always_comb begin
		active     = !halted_q && !sym_bad(item_q.letter);
		exec_we    = 1'b0;
		exec_wdata = rdata_q;
		cursor_d   = cursor_q;
		free_d     = free_q;
		halted_d   = halted_q;
		ovf_d      = ovf_q;
		matched_d  = matched_q;
		pos_d      = (pos_q < LEN_MAX) ? pos_q + LEN_W'(1) : pos_q;
		if (!halted_q && sym_bad(item_q.letter)) halted_d = 1'b1;
		if (active) begin
			if (item_q.cmd == CMD_INSERT) begin
				if (rdata_q.ptr == '0) begin
					if (free_q >= FREE_END) begin
						ovf_d    = 1'b1;
						halted_d = 1'b1;
					end else begin
						exec_we        = 1'b1;
						exec_wdata.ptr = free_q[NODE_W-1:0];
						exec_wdata.cnt = PASS_ONE;
						cursor_d       = free_q[NODE_W-1:0];
						free_d         = free_q + FREE_W'(1);
					end
				end else begin
					exec_we        = 1'b1;
					exec_wdata.cnt = (rdata_q.cnt == PASS_MAX) ? PASS_MAX
					                 : rdata_q.cnt + CNT_W'(1);
					cursor_d       = rdata_q.ptr;
				end
			end else begin
				if (rdata_q.ptr == '0 || rdata_q.cnt <= PASS_ONE) begin
					halted_d = 1'b1;
				end else begin
					cursor_d  = rdata_q.ptr;
					matched_d = pos_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			free_q    <= FREE_W'(1);
			pos_q     <= '0;
			matched_q <= '0;
			halted_q  <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (cmd.finish) begin
			free_q <= free_d;
			ovf_q  <= ovf_d;
			if (item_q.word_end) begin
				cursor_q  <= '0;
				pos_q     <= '0;
				matched_q <= '0;
				halted_q  <= 1'b0;
			end else begin
				cursor_q  <= cursor_d;
				pos_q     <= pos_d;
				matched_q <= matched_d;
				halted_q  <= halted_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && item_q.word_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && item_q.word_end) begin
			out_item_q.prefix_len <= (item_q.cmd == CMD_QUERY) ? matched_d : '0;
			out_item_q.pool_full  <= ovf_d;
		end
	end

	assign status.clear_done = (clr_cnt_q == SLOT_LAST);
	assign status.hold_last  = item_q.word_end;
	assign status.out_busy   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### src/tpsl_checker.sv
// ----------------------------------------------------------------------------
// tpsl_checker
// port-level checks for the trie prefix-share length block
// ----------------------------------------------------------------------------
module tpsl_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input tpsl_pkg::in_word_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input tpsl_pkg::out_word_t out_item
);
	import tpsl_pkg::*;

	// pool-full seen on a delivered result
	logic full_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_seen_q <= 1'b0;
		end else if (out_valid && out_ready && out_item.pool_full) begin
			full_seen_q <= 1'b1;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// every accept is followed by in_ready low (no back-to-back accepts)
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("back-to-back accept");

	// a new result only appears in an execute cycle
	a_res_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared outside execute");

	// pool-full is sticky
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_seen_q |-> out_item.pool_full)
		else $error("pool_full dropped");

endmodule

bind trie_prefix_share_length tpsl_checker u_tpsl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

### dv/tb_trie_prefix_share_length.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trie_prefix_share_length
// self-checking bench: strings of letter words go in, and each result word
// is compared field by field against a software trie walk kept in step with
// every accepted input
// ----------------------------------------------------------------------------

// expected-result store plus its own trie, updated on every accepted in word
class prefix_share_board;
	logic [tpsl_pkg::NODE_W-1:0] child_of [tpsl_pkg::SLOTS];
	logic [tpsl_pkg::CNT_W-1:0]  passes [tpsl_pkg::NODE_COUNT];
	logic [tpsl_pkg::FREE_W-1:0] next_free;
	logic [tpsl_pkg::NODE_W-1:0] at_node;
	logic [tpsl_pkg::LEN_W-1:0]  depth;
	logic [tpsl_pkg::LEN_W-1:0]  shared_len;
	logic                        stopped;
	logic                        full_seen;
	tpsl_pkg::out_word_t         pending [$];
	int                          errors;

	function new();
		for (int i = 0; i < tpsl_pkg::SLOTS; i++)
			child_of[i] = '0;
		for (int i = 0; i < tpsl_pkg::NODE_COUNT; i++)
			passes[i] = '0;
		next_free  = tpsl_pkg::FREE_W'(1);
		at_node    = '0;
		depth      = '0;
		shared_len = '0;
		stopped    = 1'b0;
		full_seen  = 1'b0;
		errors     = 0;
	endfunction

	// one letter of the walk; pushes a result on the last letter
	function void note_word(tpsl_pkg::in_word_t w);
		logic [tpsl_pkg::NODE_W-1:0] nxt;
		int                          slot;
		int                          grown;
		tpsl_pkg::out_word_t         res;
		if (!stopped) begin
			if (w.letter >= tpsl_pkg::ALPHABET) begin
				stopped = 1'b1;
			end else begin
				slot = int'(at_node) * tpsl_pkg::ALPHABET + int'(w.letter);
				nxt  = child_of[slot];
				if (w.cmd == tpsl_pkg::CMD_INSERT) begin
					if (nxt == '0 && next_free >= tpsl_pkg::NODE_COUNT) begin
						full_seen = 1'b1;
						stopped   = 1'b1;
					end else begin
						if (nxt == '0) begin
							nxt            = next_free[tpsl_pkg::NODE_W-1:0];
							next_free      = next_free + tpsl_pkg::FREE_W'(1);
							child_of[slot] = nxt;
						end
						at_node = nxt;
						if (passes[nxt] < tpsl_pkg::PASS_MAX)
							passes[nxt] = passes[nxt] + tpsl_pkg::CNT_W'(1);
					end
				end else begin
					if (nxt == '0 || passes[nxt] <= tpsl_pkg::PASS_ONE) begin
						stopped = 1'b1;
					end else begin
						at_node = nxt;
						grown   = int'(depth) + 1;
						if (grown > tpsl_pkg::LEN_CAP)
							grown = tpsl_pkg::LEN_CAP;
						shared_len = grown[tpsl_pkg::LEN_W-1:0];
					end
				end
			end
		end
		if (depth < tpsl_pkg::LEN_CAP)
			depth = depth + tpsl_pkg::LEN_W'(1);
		if (w.word_end) begin
			res.prefix_len = (w.cmd == tpsl_pkg::CMD_INSERT) ? '0 : shared_len;
			res.pool_full  = full_seen;
			pending.push_back(res);
			at_node    = '0;
			depth      = '0;
			shared_len = '0;
			stopped    = 1'b0;
		end
	endfunction

	function void check_word(tpsl_pkg::out_word_t got);
		tpsl_pkg::out_word_t want;
		if (pending.size() == 0) begin
			$display("%0t unexpected result: expected none, actual len %0d full %0b",
				$time, got.prefix_len, got.pool_full);
			errors++;
		end else begin
			want = pending.pop_front();
			if (got.prefix_len !== want.prefix_len) begin
				$display("%0t prefix_len mismatch: expected %0d, actual %0d",
					$time, want.prefix_len, got.prefix_len);
				errors++;
			end
			if (got.pool_full !== want.pool_full) begin
				$display("%0t pool_full mismatch: expected %0b, actual %0b",
					$time, want.pool_full, got.pool_full);
				errors++;
			end
		end
	endfunction
endclass

module tb_trie_prefix_share_length;
	import tpsl_pkg::*;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_item;

	// idle odds in percent for each side, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent_words    = 0;

	prefix_share_board board;

	trie_prefix_share_length u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver stalls at random per cycle
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// both handshakes are seen here with their pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_word(in_item);
			if (out_valid && out_ready)
				board.check_word(out_item);
		end
	end

	// mostly a small alphabet so strings share prefixes, now and then any code
	function automatic logic [LETTER_W-1:0] pick_letter();
		int roll;
		roll = $urandom_range(99);
		if (roll < 85)
			return LETTER_W'($urandom_range(3));
		else if (roll < 95)
			return LETTER_W'($urandom_range(ALPHABET - 1));
		else
			return LETTER_W'($urandom_range(31));
	endfunction

	// one in word: optional idle cycles, then hold valid until taken
	task automatic drive_in_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_words++;
	endtask

	task automatic send_letter(input logic cmd, input int letter, input logic last);
		in_word_t w;
		w.cmd      = cmd;
		w.letter   = LETTER_W'(letter);
		w.word_end = last;
		drive_in_word(w);
	endtask

	// random string; one letter in ten flips the command as noise
	task automatic send_random_string(input int max_len, input bit only_insert);
		logic     str_cmd;
		int       len;
		in_word_t w;
		str_cmd = only_insert ? CMD_INSERT : logic'($urandom_range(1));
		if ($urandom_range(4) == 0)
			len = $urandom_range(max_len, 7);
		else
			len = $urandom_range(6, 1);
		for (int i = 0; i < len; i++) begin
			w.cmd      = ($urandom_range(9) == 0 && !only_insert) ? ~str_cmd : str_cmd;
			w.letter   = only_insert ? LETTER_W'($urandom_range(ALPHABET - 1)) : pick_letter();
			w.word_end = (i == len - 1);
			drive_in_word(w);
		end
	endtask

	task automatic run_random(input int words_wanted);
		int stop_at;
		stop_at = sent_words + words_wanted;
		while (sent_words < stop_at)
			send_random_string(20, 1'b0);
	endtask

	initial begin
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles often-ish, receiver mostly stalls
		send_idle_pct = 29;
		recv_idle_pct = 75;

		// directed: shared paths, z as the top letter, pass count saturation
		send_letter(CMD_INSERT, 0, 1'b0);
		send_letter(CMD_INSERT, 25, 1'b1);
		send_letter(CMD_INSERT, 0, 1'b0);
		send_letter(CMD_INSERT, 25, 1'b0);
		send_letter(CMD_INSERT, 3, 1'b1);
		// query stops where the third letter was entered only once
		send_letter(CMD_QUERY, 0, 1'b0);
		send_letter(CMD_QUERY, 25, 1'b0);
		send_letter(CMD_QUERY, 3, 1'b1);
		// letter code past the alphabet halts the query walk
		send_letter(CMD_QUERY, 0, 1'b0);
		send_letter(CMD_QUERY, 31, 1'b1);
		// same on an insert, nothing built
		send_letter(CMD_INSERT, 31, 1'b1);
		// query of a missing child
		send_letter(CMD_QUERY, 1, 1'b1);
		// mixed commands, result follows the last letter
		send_letter(CMD_INSERT, 0, 1'b0);
		send_letter(CMD_QUERY, 25, 1'b1);
		send_letter(CMD_QUERY, 0, 1'b0);
		send_letter(CMD_INSERT, 26, 1'b1);
		// fourth pass over the first node, count stays saturated
		send_letter(CMD_INSERT, 0, 1'b1);
		send_letter(CMD_QUERY, 0, 1'b1);

		run_random(190);

		// swap the idle odds between the two sides
		send_idle_pct = 75;
		recv_idle_pct = 29;
		run_random(190);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(190);
		in_valid <= 1'b0;

		// drain, then keep watching for any stray result
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// hang guard: covers the table clear after reset and the slowest stalls
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### filelist.f
src/tpsl_pkg.sv
src/tpsl_ctrl.sv
src/tpsl_datapath.sv
src/trie_prefix_share_length.sv
src/tpsl_checker.sv
dv/tb_trie_prefix_share_length.sv
